// File: src/jzc_pkg.sv
// ----------------------------------------------------------------------------
// jzc_pkg
// Shared types and constants for the joystick zone classifier.
// ----------------------------------------------------------------------------
package jzc_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int DZ_BITS     = 8;
	localparam int DEFL_BITS   = 8;
	localparam int ZONE_BITS   = 3;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = SAMPLE_BITS;
	localparam int DIV_STEPS   = DEFL_BITS;
	localparam int STEP_BITS   = $clog2(DIV_STEPS);

	localparam logic [SAMPLE_BITS-1:0] RAIL_MAX = {SAMPLE_BITS{1'b1}};

	localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(512);
	localparam logic [DZ_BITS-1:0]     DEAD_ZONE_RESET = DZ_BITS'(60);
	localparam logic [DZ_BITS-1:0]     HYST_RESET      = DZ_BITS'(20);

	localparam logic [ZONE_BITS-1:0] ZONE_CTR = 3'd0;
	localparam logic [ZONE_BITS-1:0] ZONE_RT  = 3'd1;
	localparam logic [ZONE_BITS-1:0] ZONE_LT  = 3'd2;
	localparam logic [ZONE_BITS-1:0] ZONE_UP  = 3'd3;
	localparam logic [ZONE_BITS-1:0] ZONE_DN  = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_ZONE = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HYST      = 2'd3;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_x;
		logic [SAMPLE_BITS-1:0] sample_y;
	} in_beat_t;

	typedef struct packed {
		logic [ZONE_BITS-1:0] zone;
		logic [DEFL_BITS-1:0] deflection;
		logic                 zone_changed;
	} out_beat_t;

	typedef struct packed {
		logic capture;
		logic classify;
		logic div_step;
		logic load_out;
	} cmd_t;

endpackage

// File: src/jzc_ctrl.sv
// ----------------------------------------------------------------------------
// jzc_ctrl
// Sequencer: capture, classify, eight divide steps, then hand off to the
// output register. Owns both handshakes.
// ----------------------------------------------------------------------------
module jzc_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output jzc_pkg::cmd_t cmd
);
	import jzc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLASS = 4'b0010,
		S_DIV   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] step_q;
	logic                 out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CLASS;
				end
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_BITS'(DIV_STEPS - 1))
					state_d = S_DONE;
			end
			S_DONE: begin
				// output slot must be free or emptying this cycle
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.classify)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/jzc_datapath.sv
// ----------------------------------------------------------------------------
// jzc_datapath
// Config registers, offset and zone logic, restoring Q0.8 divider and the
// output register.
// ----------------------------------------------------------------------------
module jzc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jzc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [jzc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  jzc_pkg::in_beat_t                 in_data,
	input  jzc_pkg::cmd_t                     cmd,
	output jzc_pkg::out_beat_t                out_data
);
	import jzc_pkg::*;

	logic [SAMPLE_BITS-1:0] center_x_q, center_y_q;
	logic [DZ_BITS-1:0]     dead_zone_q, hyst_q;
	logic [ZONE_BITS-1:0]   zone_q;

	logic [SAMPLE_BITS-1:0] sx_q, sy_q;
	logic [ZONE_BITS-1:0]   res_zone_q;
	logic                   changed_q;
	logic                   zero_q, sat_q;
	logic [SAMPLE_BITS-1:0] rem_q, den_q;
	logic [DEFL_BITS-1:0]   quot_q;
	out_beat_t              out_q;

	logic [SAMPLE_BITS-1:0] ax, ay, span_x, span_y, mag, span, num, den, rx, ry;
	logic [DZ_BITS:0]       limit;
	logic [SAMPLE_BITS-1:0] limit_w, dz_w;
	logic                   is_center, x_dom;
	logic [ZONE_BITS-1:0]   zone_d;
	logic [SAMPLE_BITS:0]   r2;
	logic                   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= CENTER_RESET;
			center_y_q  <= CENTER_RESET;
			dead_zone_q <= DEAD_ZONE_RESET;
			hyst_q      <= HYST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_X:  center_x_q  <= cfg_data;
				CFG_CENTER_Y:  center_y_q  <= cfg_data;
				CFG_DEAD_ZONE: dead_zone_q <= cfg_data[DZ_BITS-1:0];
				CFG_HYST:      hyst_q      <= cfg_data[DZ_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ax = (sx_q >= center_x_q) ? sx_q - center_x_q : center_x_q - sx_q;
		ay = (sy_q >= center_y_q) ? sy_q - center_y_q : center_y_q - sy_q;
		rx = RAIL_MAX - center_x_q;
		ry = RAIL_MAX - center_y_q;
		span_x = (center_x_q > rx) ? center_x_q : rx;
		span_y = (center_y_q > ry) ? center_y_q : ry;

		// leaving center needs the extra margin, any other zone counts as outside
		if (zone_q == ZONE_CTR)
			limit = {1'b0, dead_zone_q} + {1'b0, hyst_q};
		else
			limit = {1'b0, dead_zone_q};
		limit_w = SAMPLE_BITS'(limit);
		dz_w    = SAMPLE_BITS'(dead_zone_q);

		is_center = (ax <= limit_w) && (ay <= limit_w);
		x_dom     = (ax >= ay);
		if (is_center)
			zone_d = ZONE_CTR;
		else if (x_dom)
			zone_d = (sx_q > center_x_q) ? ZONE_LT : ZONE_RT;
		else
			zone_d = (sy_q > center_y_q) ? ZONE_DN : ZONE_UP;

		mag  = x_dom ? ax : ay;
		span = x_dom ? span_x : span_y;
		num  = mag - dz_w;
		den  = span - dz_w;

		r2   = {rem_q, 1'b0};
		take = (r2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			zone_q <= ZONE_CTR;
		else if (cmd.classify)
			zone_q <= zone_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sx_q <= in_data.sample_x;
			sy_q <= in_data.sample_y;
		end
		if (cmd.classify) begin
			res_zone_q <= zone_d;
			changed_q  <= (zone_d != zone_q);
			zero_q     <= is_center || (mag <= dz_w);
			sat_q      <= (span <= dz_w) || (num >= den);
			rem_q      <= num;
			den_q      <= den;
			quot_q     <= '0;
		end else if (cmd.div_step) begin
			if (take)
				rem_q <= SAMPLE_BITS'(r2 - {1'b0, den_q});
			else
				rem_q <= r2[SAMPLE_BITS-1:0];
			quot_q <= {quot_q[DEFL_BITS-2:0], take};
		end
		if (cmd.load_out) begin
			out_q.zone         <= res_zone_q;
			out_q.zone_changed <= changed_q;
			if (zero_q)
				out_q.deflection <= '0;
			else if (sat_q)
				out_q.deflection <= {DEFL_BITS{1'b1}};
			else
				out_q.deflection <= quot_q;
		end
	end

	assign out_data = out_q;

endmodule

// File: src/joystick_zone_classifier_unit.sv
// Sequence: the input beat is captured, classified, divided one quotient bit
//   per cycle by the restoring divider, then loaded into the output register.
// Flow: one item in flight; a new beat is taken only after the last result
//   is loaded, which waits while the output register holds an untaken beat.
// Reset: async active low; registers return to defaults, zone to center.
// ----------------------------------------------------------------------------
// joystick_zone_classifier_unit
// Classifies a joystick sample pair into a zone with Q0.8 deflection.
// ----------------------------------------------------------------------------
module joystick_zone_classifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jzc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [jzc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  jzc_pkg::in_beat_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output jzc_pkg::out_beat_t                out_data
);
	import jzc_pkg::*;

	cmd_t cmd;

	jzc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	jzc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

// File: src/jzc_checker.sv
// ----------------------------------------------------------------------------
// jzc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module jzc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input jzc_pkg::out_beat_t out_data
);
	import jzc_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	a_center_no_defl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.zone != ZONE_CTR || out_data.deflection == '0))
		else $error("center zone with nonzero deflection");

	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.zone == ZONE_CTR || out_data.zone == ZONE_RT ||
			out_data.zone == ZONE_LT || out_data.zone == ZONE_UP ||
			out_data.zone == ZONE_DN))
		else $error("zone code out of range");

endmodule

bind joystick_zone_classifier_unit jzc_checker u_jzc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: tb/sv/jzc_zone_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jzc_zone_checker
// Watches the config port and both streams of the zone classifier, predicts
// each result beat from its own copy of the registers and zone state, and
// compares every output beat field by field in order.
// ----------------------------------------------------------------------------
module jzc_zone_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jzc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [jzc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  jzc_pkg::in_beat_t                 in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  jzc_pkg::out_beat_t                out_data,
	output int                                error_count,
	output int                                pending_count,
	output int                                checked_count
);
	import jzc_pkg::*;

	logic [SAMPLE_BITS-1:0] center_x_q;
	logic [SAMPLE_BITS-1:0] center_y_q;
	logic [DZ_BITS-1:0]     dead_zone_q;
	logic [DZ_BITS-1:0]     hyst_q;
	logic [ZONE_BITS-1:0]   zone_q;
	out_beat_t              expected_zone_q[$];
	out_beat_t              exp_beat;
	out_beat_t              new_beat;
	int                     n_errors = 0;
	int                     n_checked = 0;
	int                     n_pending = 0;

	assign error_count   = n_errors;
	assign pending_count = n_pending;
	assign checked_count = n_checked;

	function automatic logic [SAMPLE_BITS-1:0] offset_mag(input logic [SAMPLE_BITS-1:0] a,
			input logic [SAMPLE_BITS-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// larger distance from the center to either rail
	function automatic logic [SAMPLE_BITS-1:0] rail_dist(input logic [SAMPLE_BITS-1:0] c);
		logic [SAMPLE_BITS-1:0] to_top;
		to_top = RAIL_MAX - c;
		return (c > to_top) ? c : to_top;
	endfunction

	function automatic logic [DEFL_BITS-1:0] q08_deflection(input logic [SAMPLE_BITS-1:0] mag,
			input logic [SAMPLE_BITS-1:0] span);
		int unsigned num;
		int unsigned den;
		int unsigned q;
		if (mag <= dead_zone_q)
			return '0;
		if (span <= dead_zone_q)
			return '1;
		num = int'(mag) - int'(dead_zone_q);
		den = int'(span) - int'(dead_zone_q);
		if (num >= den)
			return '1;
		q = (num * 256) / den;
		return (q > 255) ? '1 : q[DEFL_BITS-1:0];
	endfunction

	function automatic out_beat_t classify_sample(input in_beat_t s);
		out_beat_t r;
		logic [SAMPLE_BITS-1:0] ax;
		logic [SAMPLE_BITS-1:0] ay;
		logic [DZ_BITS:0]       limit;
		ax = offset_mag(s.sample_x, center_x_q);
		ay = offset_mag(s.sample_y, center_y_q);
		// leaving center takes the extra hysteresis margin
		if (zone_q == ZONE_CTR)
			limit = {1'b0, dead_zone_q} + {1'b0, hyst_q};
		else
			limit = {1'b0, dead_zone_q};
		if (ax <= limit && ay <= limit) begin
			r.zone       = ZONE_CTR;
			r.deflection = '0;
		end else if (ax >= ay) begin
			// positive X offset reads as left
			r.zone       = (s.sample_x > center_x_q) ? ZONE_LT : ZONE_RT;
			r.deflection = q08_deflection(ax, rail_dist(center_x_q));
		end else begin
			r.zone       = (s.sample_y > center_y_q) ? ZONE_DN : ZONE_UP;
			r.deflection = q08_deflection(ay, rail_dist(center_y_q));
		end
		r.zone_changed = (r.zone != zone_q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  = CENTER_RESET;
			center_y_q  = CENTER_RESET;
			dead_zone_q = DEAD_ZONE_RESET;
			hyst_q      = HYST_RESET;
			zone_q      = ZONE_CTR;
			expected_zone_q.delete();
			n_pending   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_zone_q.size() == 0) begin
					$error("unexpected result beat: zone %0d deflection %0d",
						out_data.zone, out_data.deflection);
					n_errors++;
				end else begin
					exp_beat = expected_zone_q.pop_front();
					n_checked++;
					if (out_data.zone !== exp_beat.zone) begin
						$error("zone: expected %0d, actual %0d", exp_beat.zone, out_data.zone);
						n_errors++;
					end
					if (out_data.deflection !== exp_beat.deflection) begin
						$error("deflection: expected %0d, actual %0d",
							exp_beat.deflection, out_data.deflection);
						n_errors++;
					end
					if (out_data.zone_changed !== exp_beat.zone_changed) begin
						$error("zone_changed: expected %0d, actual %0d",
							exp_beat.zone_changed, out_data.zone_changed);
						n_errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				new_beat = classify_sample(in_data);
				zone_q   = new_beat.zone;
				expected_zone_q.push_back(new_beat);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CENTER_X:  center_x_q  = cfg_data[SAMPLE_BITS-1:0];
					CFG_CENTER_Y:  center_y_q  = cfg_data[SAMPLE_BITS-1:0];
					CFG_DEAD_ZONE: dead_zone_q = cfg_data[DZ_BITS-1:0];
					CFG_HYST:      hyst_q      = cfg_data[DZ_BITS-1:0];
					default: ;
				endcase
			end
			n_pending = expected_zone_q.size();
		end
	end

endmodule

// File: tb/sv/tb_joystick_zone_classifier_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_zone_classifier_unit
// Drives sample pairs into the zone classifier under several register
// settings, with bursty input and a stalling output, and lets the checker
// compare every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_joystick_zone_classifier_unit;
	import jzc_pkg::*;

	localparam int RANDOM_PHASES    = 6;
	localparam int BEATS_PER_PHASE  = 300;
	localparam int DRAIN_CYCLES     = 24;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	in_beat_t                 in_data;
	logic                     out_valid;
	logic                     out_ready;
	out_beat_t                out_data;

	int error_count;
	int pending_count;
	int checked_count;
	int beats_sent = 0;
	int settings_used = 0;
	int burst_left = 0;
	bit hold_off_req = 1'b0;

	// stimulus-side copy of the settings, only used to aim samples at thresholds
	logic [SAMPLE_BITS-1:0] cur_cx;
	logic [SAMPLE_BITS-1:0] cur_cy;
	logic [DZ_BITS-1:0]     cur_dz;
	logic [DZ_BITS-1:0]     cur_hy;

	joystick_zone_classifier_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	jzc_zone_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.error_count   (error_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

	// output side: random stall patterns, plus one long hold-off on request
	initial begin
		int       seg;
		rx_mode_t mode;
		bit       hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			if (hold_off_req && !hold_done) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			seg  = $urandom_range(10, 150);
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
					default:   out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_beat(input logic [SAMPLE_BITS-1:0] sx, input logic [SAMPLE_BITS-1:0] sy);
		in_beat_t b;
		int       gap;
		b.sample_x = sx;
		b.sample_y = sy;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(0, 60);
		end
	endtask

	// drop valid and wait out every outstanding result plus the pipeline
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_setting(input logic [SAMPLE_BITS-1:0] cx, input logic [SAMPLE_BITS-1:0] cy,
			input logic [DZ_BITS-1:0] dz, input logic [DZ_BITS-1:0] hy);
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_DEAD_ZONE, CFG_DATA_BITS'(dz));
		write_reg(CFG_HYST, CFG_DATA_BITS'(hy));
		cur_cx = cx;
		cur_cy = cy;
		cur_dz = dz;
		cur_hy = hy;
		settings_used++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] offset_from(input logic [SAMPLE_BITS-1:0] c,
			input int reach);
		int v;
		v = ($urandom_range(0, 1) == 1) ? int'(c) + reach : int'(c) - reach;
		if (v < 0)
			v = 0;
		if (v > int'(RAIL_MAX))
			v = int'(RAIL_MAX);
		return v[SAMPLE_BITS-1:0];
	endfunction

	// mix of uniform samples, threshold probes and large throws with a quiet cross axis
	task automatic send_random_beat();
		int kind;
		int lim;
		int d_main;
		int d_cross;
		bit on_x;
		kind    = $urandom_range(0, 9);
		on_x    = ($urandom_range(0, 1) == 1);
		d_cross = $urandom_range(0, cur_dz);
		if (kind < 3) begin
			send_beat(SAMPLE_BITS'($urandom_range(0, RAIL_MAX)),
				SAMPLE_BITS'($urandom_range(0, RAIL_MAX)));
		end else begin
			if (kind < 7) begin
				lim    = ($urandom_range(0, 1) == 1) ? int'(cur_dz) + int'(cur_hy) : int'(cur_dz);
				d_main = lim + int'($urandom_range(0, 4)) - 2;
				if (d_main < 0)
					d_main = 0;
			end else begin
				d_main = $urandom_range(cur_dz, RAIL_MAX);
			end
			if (on_x)
				send_beat(offset_from(cur_cx, d_main), offset_from(cur_cy, d_cross));
			else
				send_beat(offset_from(cur_cx, d_cross), offset_from(cur_cy, d_main));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		cur_cx    = CENTER_RESET;
		cur_cy    = CENTER_RESET;
		cur_dz    = DEAD_ZONE_RESET;
		cur_hy    = HYST_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: hysteresis edges, every zone, ties, rails
		send_beat(10'd512, 10'd512);
		send_beat(10'd592, 10'd512);
		send_beat(10'd593, 10'd512);
		send_beat(10'd573, 10'd512);
		send_beat(10'd572, 10'd512);
		send_beat(10'd573, 10'd512);
		send_beat(10'd0,   10'd512);
		send_beat(10'd512, 10'd0);
		send_beat(10'd512, 10'd1023);
		send_beat(10'd1023, 10'd512);
		send_beat(10'd612, 10'd412);
		send_beat(10'd412, 10'd612);
		send_beat(10'd0,   10'd0);
		send_beat(10'd1023, 10'd1023);
		send_beat(10'd0,   10'd1023);
		send_beat(10'd1023, 10'd0);
		send_beat(10'h2AA, 10'h155);
		send_beat(10'h155, 10'h2AA);
		send_beat(10'd512, 10'd512);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_setting('0, RAIL_MAX, '0, '0);
				1: apply_setting(RAIL_MAX, '0, '1, '1);
				default: apply_setting(SAMPLE_BITS'($urandom_range(0, RAIL_MAX)),
					SAMPLE_BITS'($urandom_range(0, RAIL_MAX)),
					DZ_BITS'($urandom_range(0, 255)), DZ_BITS'($urandom_range(0, 255)));
			endcase
			if (p == 2)
				hold_off_req = 1'b1;
			repeat (BEATS_PER_PHASE) send_random_beat();
			wait_idle();
		end

		$display("Checked %0d result beats from %0d sample beats over %0d register settings",
			checked_count, beats_sent, settings_used);
		$display("Includes threshold probes, rail throws and a %0d-cycle output hold-off",
			LONG_HOLD_CYCLES);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
